/* rtl/core/gmpa_pkg.sv */
// Shared constants, types and helpers of the grouped matrix-vector partial accumulator.
package gmpa_pkg;

	localparam int GROUPS_MAX_DEF    = 4;
	localparam int PENCILS_MAX_DEF   = 8;
	localparam int IN_DEPTH_MAX_DEF  = 16;
	localparam int OUT_DEPTH_MAX_DEF = 16;

	localparam int VALUE_W = 16;
	localparam int PROD_W  = 32;
	localparam int ACC_W   = 40;
	localparam int DEPTH_W = 5;
	localparam int GROUP_W = 3;
	localparam int CFG_W   = 5;

	localparam logic [1:0] REG_IN_DEPTH   = 2'd0;
	localparam logic [1:0] REG_OUT_DEPTH  = 2'd1;
	localparam logic [1:0] REG_NUM_GROUPS = 2'd2;

	localparam logic MODE_WEIGHT = 1'b0;
	localparam logic MODE_DATA   = 1'b1;

	typedef struct packed {
		logic [DEPTH_W-1:0] in_depth;
		logic [DEPTH_W-1:0] out_depth;
		logic [GROUP_W-1:0] num_groups;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic first;
	} mac_ctrl_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_MUL  = 4'b0100,
		ST_ACC  = 4'b1000
	} seq_state_t;

	function automatic int addr_w(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

/* rtl/core/gmpa_if.sv */
// Input and result channel interfaces of the grouped matrix-vector partial accumulator.
interface gmpa_in_if import gmpa_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      mode;
	logic [1:0]                group;
	logic [2:0]                pencil;
	logic [3:0]                in_index;
	logic [3:0]                out_index;
	logic signed [VALUE_W-1:0] value;

	modport source(output valid, mode, group, pencil, in_index, out_index, value, input ready);
	modport sink(input valid, mode, group, pencil, in_index, out_index, value, output ready);
endinterface

interface gmpa_out_if import gmpa_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [2:0]              out_pencil;
	logic [3:0]              out_channel;
	logic signed [ACC_W-1:0] partial_sum;
	logic                    last;

	modport source(output valid, out_pencil, out_channel, partial_sum, last, input ready);
	modport sink(input valid, out_pencil, out_channel, partial_sum, last, output ready);
endinterface

/* rtl/core/grouped_matvec_partial_accumulator.sv */
// A weight transaction is written to the weight RAM on acceptance; the block stays ready.
// A data transaction runs one multiply-accumulate per output channel, each passing
// through a RAM read, a registered product and a saturating add, while ready is low.
// Results go out only for the last group and input index of a pencil; a result not yet taken stalls the add.
// Reset clears the sequencer, the result valid and sets in_depth 16, out_depth 16,
// num_groups 1; the weight and accumulator RAMs are not cleared.
module grouped_matvec_partial_accumulator import gmpa_pkg::*; #(
	parameter int GROUPS_MAX    = GROUPS_MAX_DEF,
	parameter int PENCILS_MAX   = PENCILS_MAX_DEF,
	parameter int IN_DEPTH_MAX  = IN_DEPTH_MAX_DEF,
	parameter int OUT_DEPTH_MAX = OUT_DEPTH_MAX_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	gmpa_in_if.sink          item,
	gmpa_out_if.source       result,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);

	localparam int W_DEPTH = GROUPS_MAX * OUT_DEPTH_MAX * IN_DEPTH_MAX;
	localparam int A_DEPTH = PENCILS_MAX * OUT_DEPTH_MAX;
	localparam int WA      = addr_w(W_DEPTH);
	localparam int AA      = addr_w(A_DEPTH);

	cfg_t                      cfg_q;
	logic                      w_we;
	logic [WA-1:0]             w_waddr;
	logic [WA-1:0]             w_raddr;
	logic [VALUE_W-1:0]        w_rdata;
	logic                      a_we;
	logic [AA-1:0]             a_addr;
	logic [ACC_W-1:0]          a_rdata;
	logic signed [VALUE_W-1:0] data;
	logic signed [ACC_W-1:0]   mac_result;
	mac_ctrl_t                 mac_ctrl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.in_depth   <= DEPTH_W'(16);
			cfg_q.out_depth  <= DEPTH_W'(16);
			cfg_q.num_groups <= GROUP_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IN_DEPTH:   cfg_q.in_depth   <= cfg_wdata[DEPTH_W-1:0];
				REG_OUT_DEPTH:  cfg_q.out_depth  <= cfg_wdata[DEPTH_W-1:0];
				REG_NUM_GROUPS: cfg_q.num_groups <= cfg_wdata[GROUP_W-1:0];
				default: ;
			endcase
		end
	end

	gmpa_seq #(
		.GROUPS_MAX   (GROUPS_MAX),
		.PENCILS_MAX  (PENCILS_MAX),
		.IN_DEPTH_MAX (IN_DEPTH_MAX),
		.OUT_DEPTH_MAX(OUT_DEPTH_MAX),
		.WA           (WA),
		.AA           (AA)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.item      (item),
		.result    (result),
		.w_we      (w_we),
		.w_waddr   (w_waddr),
		.w_raddr   (w_raddr),
		.a_we      (a_we),
		.a_addr    (a_addr),
		.data      (data),
		.mac_ctrl  (mac_ctrl),
		.mac_result(mac_result)
	);

	gmpa_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(W_DEPTH)
	) u_weight_ram (
		.clk  (clk),
		.we   (w_we),
		.waddr(w_waddr),
		.wdata(item.value),
		.raddr(w_raddr),
		.rdata(w_rdata)
	);

	gmpa_ram #(
		.WIDTH(ACC_W),
		.DEPTH(A_DEPTH)
	) u_acc_ram (
		.clk  (clk),
		.we   (a_we),
		.waddr(a_addr),
		.wdata(mac_result),
		.raddr(a_addr),
		.rdata(a_rdata)
	);

	gmpa_mac u_mac (
		.clk   (clk),
		.ctrl  (mac_ctrl),
		.weight(w_rdata),
		.data  (data),
		.acc_in(a_rdata),
		.result(mac_result)
	);

endmodule

/* rtl/core/gmpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module gmpa_ram import gmpa_pkg::*; #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [addr_w(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]          wdata,
	input  logic [addr_w(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/core/gmpa_mac.sv */
// Shared multiply-accumulate unit with a registered product and 40-bit saturation.
module gmpa_mac import gmpa_pkg::*; (
	input  logic                      clk,
	input  mac_ctrl_t                 ctrl,
	input  logic signed [VALUE_W-1:0] weight,
	input  logic signed [VALUE_W-1:0] data,
	input  logic signed [ACC_W-1:0]   acc_in,
	output logic signed [ACC_W-1:0]   result
);

	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     first_q;
	logic signed [ACC_W:0]    sum;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			prod_q  <= PROD_W'(weight) * PROD_W'(data);
			acc_q   <= acc_in;
			first_q <= ctrl.first;
		end
	end

	always_comb begin
		sum = (ACC_W+1)'(acc_q) + (ACC_W+1)'(prod_q);
		if (first_q) begin
			result = ACC_W'(prod_q);
		end else if (sum[ACC_W] != sum[ACC_W-1]) begin
			result = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			result = sum[ACC_W-1:0];
		end
	end

endmodule

/* rtl/core/gmpa_seq.sv */
// Sequencer that steps one data element through all output channels and drives the results.
module gmpa_seq import gmpa_pkg::*; #(
	parameter int GROUPS_MAX    = GROUPS_MAX_DEF,
	parameter int PENCILS_MAX   = PENCILS_MAX_DEF,
	parameter int IN_DEPTH_MAX  = IN_DEPTH_MAX_DEF,
	parameter int OUT_DEPTH_MAX = OUT_DEPTH_MAX_DEF,
	parameter int WA            = addr_w(GROUPS_MAX * OUT_DEPTH_MAX * IN_DEPTH_MAX),
	parameter int AA            = addr_w(PENCILS_MAX * OUT_DEPTH_MAX)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cfg_t                      cfg,
	gmpa_in_if.sink                   item,
	gmpa_out_if.source                result,
	output logic                      w_we,
	output logic [WA-1:0]             w_waddr,
	output logic [WA-1:0]             w_raddr,
	output logic                      a_we,
	output logic [AA-1:0]             a_addr,
	output logic signed [VALUE_W-1:0] data,
	output mac_ctrl_t                 mac_ctrl,
	input  logic signed [ACC_W-1:0]   mac_result
);

	localparam int KW = $clog2(OUT_DEPTH_MAX + 1);

	seq_state_t                state_q;
	logic [KW-1:0]             k_q;
	logic [1:0]                grp_q;
	logic [2:0]                pen_q;
	logic [3:0]                ic_q;
	logic                      first_q;
	logic                      emit_q;
	logic signed [VALUE_W-1:0] data_q;
	logic                      out_valid_q;
	logic [2:0]                out_pencil_q;
	logic [3:0]                out_channel_q;
	logic signed [ACC_W-1:0]   partial_sum_q;
	logic                      last_q;

	logic [DEPTH_W-1:0] id;
	logic [DEPTH_W-1:0] od;
	logic [GROUP_W-1:0] ng;
	logic               accept;
	logic               in_range;
	logic               acc_stall;
	logic               acc_go;
	logic               k_last;

	always_comb begin
		id = (32'(cfg.in_depth) > IN_DEPTH_MAX) ? DEPTH_W'(IN_DEPTH_MAX) : cfg.in_depth;
		od = (32'(cfg.out_depth) > OUT_DEPTH_MAX) ? DEPTH_W'(OUT_DEPTH_MAX) : cfg.out_depth;
		ng = (32'(cfg.num_groups) > GROUPS_MAX) ? GROUP_W'(GROUPS_MAX) : cfg.num_groups;
	end

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;
	assign in_range   = (32'(item.group) < 32'(ng)) && (32'(item.in_index) < 32'(id));

	assign w_we    = accept && in_range && (item.mode == MODE_WEIGHT)
	                 && (32'(item.out_index) < 32'(od));
	assign w_waddr = WA'((32'(item.group) * OUT_DEPTH_MAX + 32'(item.out_index)) * IN_DEPTH_MAX
	                 + 32'(item.in_index));
	assign w_raddr = WA'((32'(grp_q) * OUT_DEPTH_MAX + 32'(k_q)) * IN_DEPTH_MAX + 32'(ic_q));
	assign a_addr  = AA'(32'(pen_q) * OUT_DEPTH_MAX + 32'(k_q));
	assign data    = data_q;

	assign acc_stall = emit_q && out_valid_q && !result.ready;
	assign acc_go    = (state_q == ST_ACC) && !acc_stall;
	assign a_we      = acc_go;
	assign k_last    = (32'(k_q) == 32'(od) - 1);

	assign mac_ctrl.load  = (state_q == ST_MUL);
	assign mac_ctrl.first = first_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && in_range && (item.mode == MODE_DATA)
					    && (32'(item.pencil) < PENCILS_MAX) && (od != '0)) begin
						state_q <= ST_READ;
						k_q     <= '0;
					end
				end
				ST_READ: state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_ACC;
				ST_ACC: begin
					if (acc_go) begin
						if (k_last) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_READ;
							k_q     <= k_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			grp_q   <= item.group;
			pen_q   <= item.pencil;
			ic_q    <= item.in_index;
			data_q  <= item.value;
			first_q <= (item.group == 2'd0) && (item.in_index == 4'd0);
			emit_q  <= (32'(item.group) == 32'(ng) - 1) && (32'(item.in_index) == 32'(id) - 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc_go && emit_q) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_go && emit_q) begin
			out_pencil_q  <= pen_q;
			out_channel_q <= 4'(k_q);
			partial_sum_q <= mac_result;
			last_q        <= k_last;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.out_pencil  = out_pencil_q;
	assign result.out_channel = out_channel_q;
	assign result.partial_sum = partial_sum_q;
	assign result.last        = last_q;

endmodule

/* tb/gmpa_sum_checker.sv */
// Checker that predicts the partial sums of the accumulator and compares every result.
module gmpa_sum_checker import gmpa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	gmpa_in_if               item,
	gmpa_out_if              result,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	output int               errors,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint SUM_MAX = 64'sd549755813887;
	localparam longint SUM_MIN = -SUM_MAX - 1;

	typedef struct packed {
		logic [2:0]       pencil;
		logic [3:0]       channel;
		logic [ACC_W-1:0] sum;
		logic             last;
	} psum_t;

	psum_t                     sums_due[$];
	psum_t                     due;
	logic signed [VALUE_W-1:0] weights [GROUPS_MAX_DEF*OUT_DEPTH_MAX_DEF*IN_DEPTH_MAX_DEF];
	longint                    acc [PENCILS_MAX_DEF*OUT_DEPTH_MAX_DEF];
	logic [CFG_W-1:0]          in_depth_r;
	logic [CFG_W-1:0]          out_depth_r;
	logic [2:0]                groups_r;

	function automatic int clamp_depth(input int v, input int limit);
		return (v > limit) ? limit : v;
	endfunction

	task automatic report_mismatch(input string what);
		if (errors < 50)
			$display("%0t ns: mismatch: %s", $realtime, what);
		errors++;
	endtask

	function automatic void accumulate_item(input logic m, input logic [1:0] g,
			input logic [2:0] p, input logic [3:0] ic, input logic [3:0] oc,
			input logic signed [VALUE_W-1:0] v);
		int     id;
		int     od;
		int     ng;
		int     k;
		int     a;
		longint prod;
		longint s;
		psum_t  r;
		id = clamp_depth(in_depth_r, IN_DEPTH_MAX_DEF);
		od = clamp_depth(out_depth_r, OUT_DEPTH_MAX_DEF);
		ng = clamp_depth(groups_r, GROUPS_MAX_DEF);
		if (int'(g) >= ng || int'(ic) >= id)
			return;
		if (m == MODE_WEIGHT) begin
			if (int'(oc) >= od)
				return;
			weights[(g * OUT_DEPTH_MAX_DEF + oc) * IN_DEPTH_MAX_DEF + ic] = v;
			return;
		end
		for (k = 0; k < od; k++) begin
			prod = longint'(weights[(g * OUT_DEPTH_MAX_DEF + k) * IN_DEPTH_MAX_DEF + ic])
				* longint'(v);
			a = p * OUT_DEPTH_MAX_DEF + k;
			if (g == 0 && ic == 0) begin
				acc[a] = prod;
			end else begin
				s = acc[a] + prod;
				if (s > SUM_MAX)
					s = SUM_MAX;
				else if (s < SUM_MIN)
					s = SUM_MIN;
				acc[a] = s;
			end
		end
		if (int'(g) == ng - 1 && int'(ic) == id - 1) begin
			for (k = 0; k < od; k++) begin
				s = acc[p * OUT_DEPTH_MAX_DEF + k];
				r.pencil  = p;
				r.channel = 4'(k);
				r.sum     = s[ACC_W-1:0];
				r.last    = (k == od - 1);
				sums_due.push_back(r);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_depth_r  = 5'd16;
			out_depth_r = 5'd16;
			groups_r    = 3'd1;
			sums_due.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_IN_DEPTH: begin
						in_depth_r = cfg_wdata;
					end
					REG_OUT_DEPTH: begin
						out_depth_r = cfg_wdata;
					end
					REG_NUM_GROUPS: begin
						groups_r = cfg_wdata[2:0];
					end
					default: begin
					end
				endcase
			end
			if (result.valid && result.ready) begin
				if (sums_due.size() == 0) begin
					report_mismatch($sformatf("unexpected result pencil %0d channel %0d",
						result.out_pencil, result.out_channel));
				end else begin
					due = sums_due.pop_front();
					if (result.out_pencil !== due.pencil)
						report_mismatch($sformatf("out_pencil %0d, expected %0d",
							result.out_pencil, due.pencil));
					if (result.out_channel !== due.channel)
						report_mismatch($sformatf("out_channel %0d, expected %0d",
							result.out_channel, due.channel));
					if (result.partial_sum !== due.sum)
						report_mismatch($sformatf("partial_sum %0d, expected %0d",
							$signed(result.partial_sum), $signed(due.sum)));
					if (result.last !== due.last)
						report_mismatch($sformatf("last %0b, expected %0b",
							result.last, due.last));
				end
			end
			if (item.valid && item.ready)
				accumulate_item(item.mode, item.group, item.pencil, item.in_index,
					item.out_index, item.value);
			pending <= sums_due.size();
		end
	end

endmodule

/* tb/tb_grouped_matvec_partial_accumulator.sv */
// Top of the accumulator testbench: clock, reset, stimulus, result back-pressure and verdict.
module tb_grouped_matvec_partial_accumulator;
	timeunit 1ns;
	timeprecision 1ps;
	import gmpa_pkg::*;

	localparam int LIMIT = 600000;
	localparam int DRAIN = 64;
	localparam int HOLD  = 400;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [1:0]       cfg_index;
	logic [CFG_W-1:0] cfg_wdata;
	int               errors;
	int               pending;
	int               cycles = 0;

	int eff_id = 16;
	int eff_od = 16;
	int eff_ng = 1;
	int sent = 0;
	int idle_pct = 20;
	bit steady = 1'b0;
	bit hold_req = 1'b0;
	bit w_ok [4][16][16];
	bit acc_ok [8][16];

	gmpa_in_if  item_if();
	gmpa_out_if result_if();

	grouped_matvec_partial_accumulator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_if),
		.result    (result_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	gmpa_sum_checker sum_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_if),
		.result    (result_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.errors    (errors),
		.pending   (pending)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("grouped_matvec_partial_accumulator test failed");
			$finish;
		end
	end

	function automatic logic [15:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] corner_value(input int i);
		case (i % 4)
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'hFFFF;
			default: return 16'h0001;
		endcase
	endfunction

	function automatic bit pencil_ready(input int p);
		int k;
		for (k = 0; k < eff_od; k++)
			if (!acc_ok[p][k])
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic send(input logic m, input int g, input int p, input int ic, input int oc,
			input logic [15:0] v);
		int k;
		item_if.valid     <= 1'b1;
		item_if.mode      <= m;
		item_if.group     <= 2'(g);
		item_if.pencil    <= 3'(p);
		item_if.in_index  <= 4'(ic);
		item_if.out_index <= 4'(oc);
		item_if.value     <= v;
		@(posedge clk);
		while (!item_if.ready)
			@(posedge clk);
		if (g < eff_ng && ic < eff_id) begin
			if (m == MODE_WEIGHT) begin
				if (oc < eff_od) begin
					w_ok[g][oc][ic] = 1'b1;
					sent++;
				end
			end else begin
				sent++;
				if (g == 0 && ic == 0)
					for (k = 0; k < eff_od; k++)
						acc_ok[p][k] = 1'b1;
			end
		end
		if (!steady && $urandom_range(0, 99) < idle_pct) begin
			item_if.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	task automatic send_data(input int g, input int p, input int ic, input logic [15:0] v);
		int k;
		for (k = 0; k < eff_od; k++)
			if (!w_ok[g][k][ic])
				send(MODE_WEIGHT, g, $urandom_range(0, 7), ic, k, pick_value());
		send(MODE_DATA, g, p, ic, $urandom_range(0, 15), v);
	endtask

	task automatic rewrite_weight();
		send(MODE_WEIGHT, $urandom_range(0, eff_ng - 1), $urandom_range(0, 7),
			$urandom_range(0, eff_id - 1), $urandom_range(0, eff_od - 1), pick_value());
	endtask

	task automatic noise();
		case ($urandom_range(0, 2))
			0: begin
				if (eff_ng < GROUPS_MAX_DEF)
					send($urandom_range(0, 1), $urandom_range(eff_ng, 3), $urandom_range(0, 7),
						$urandom_range(0, 15), $urandom_range(0, 15), pick_value());
			end
			1: begin
				if (eff_id < IN_DEPTH_MAX_DEF)
					send($urandom_range(0, 1), $urandom_range(0, 3), $urandom_range(0, 7),
						$urandom_range(eff_id, 15), $urandom_range(0, 15), pick_value());
			end
			default: begin
				if (eff_od < OUT_DEPTH_MAX_DEF)
					send(MODE_WEIGHT, $urandom_range(0, 3), $urandom_range(0, 7),
						$urandom_range(0, 15), $urandom_range(eff_od, 15), pick_value());
			end
		endcase
	endtask

	task automatic scatter(input int n);
		repeat (n)
			send($urandom_range(0, 1), $urandom_range(0, 3), $urandom_range(0, 7),
				$urandom_range(0, 15), $urandom_range(0, 15), pick_value());
	endtask

	task automatic pencil_pass(input int p, input int cut);
		int g;
		int ic;
		int n;
		n = 0;
		for (g = 0; g < eff_ng; g++) begin
			for (ic = 0; ic < eff_id; ic++) begin
				if (n < cut) begin
					if ($urandom_range(0, 99) < 8)
						rewrite_weight();
					else if ($urandom_range(0, 99) < 5)
						noise();
					send_data(g, p, ic, pick_value());
					n++;
				end
			end
		end
	endtask

	task automatic random_phase(input int quota);
		int start;
		int total;
		int r;
		int p;
		int g;
		int ic;
		start = sent;
		total = eff_ng * eff_id;
		while (sent - start < quota) begin
			r = $urandom_range(0, 99);
			p = $urandom_range(0, 7);
			if (r < 65) begin
				pencil_pass(p, total);
			end else if (r < 80) begin
				pencil_pass(p, $urandom_range(1, total));
			end else if (r < 90) begin
				g  = $urandom_range(0, eff_ng - 1);
				ic = $urandom_range(0, eff_id - 1);
				if ((g != 0 || ic != 0) && !pencil_ready(p)) begin
					g  = 0;
					ic = 0;
				end
				send_data(g, p, ic, pick_value());
			end else if (r < 96) begin
				rewrite_weight();
			end else begin
				noise();
			end
		end
	endtask

	task automatic quiesce();
		item_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic set_config(input int id, input int od, input int ng);
		quiesce();
		cfg_we    <= 1'b1;
		cfg_index <= REG_IN_DEPTH;
		cfg_wdata <= CFG_W'(id);
		@(posedge clk);
		cfg_index <= REG_OUT_DEPTH;
		cfg_wdata <= CFG_W'(od);
		@(posedge clk);
		cfg_index <= REG_NUM_GROUPS;
		cfg_wdata <= CFG_W'(ng);
		@(posedge clk);
		cfg_we <= 1'b0;
		eff_id = (id > IN_DEPTH_MAX_DEF) ? IN_DEPTH_MAX_DEF : id;
		eff_od = (od > OUT_DEPTH_MAX_DEF) ? OUT_DEPTH_MAX_DEF : od;
		eff_ng = (ng > GROUPS_MAX_DEF) ? GROUPS_MAX_DEF : ng;
	endtask

	initial begin
		result_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && pending != 0) begin
				result_if.ready <= 1'b0;
				repeat (HOLD) @(posedge clk);
				hold_req = 1'b0;
			end else if (!steady && $urandom_range(0, 99) < idle_pct) begin
				result_if.ready <= 1'b0;
				repeat ($urandom_range(1, 7) - 1) @(posedge clk);
			end else begin
				result_if.ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int g;
		int oc;
		int ic;
		int p;
		int n;
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_index         <= REG_IN_DEPTH;
		cfg_wdata         <= '0;
		item_if.valid     <= 1'b0;
		item_if.mode      <= MODE_WEIGHT;
		item_if.group     <= '0;
		item_if.pencil    <= '0;
		item_if.in_index  <= '0;
		item_if.out_index <= '0;
		item_if.value     <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_config(2, 3, 2);
		for (g = 0; g < 2; g++)
			for (oc = 0; oc < 3; oc++)
				for (ic = 0; ic < 2; ic++)
					send(MODE_WEIGHT, g, $urandom_range(0, 7), ic, oc,
						corner_value(g * 6 + oc * 2 + ic));
		send(MODE_WEIGHT, 0, 0, 0, 15, 16'h1234);
		send(MODE_WEIGHT, 3, 7, 15, 0, 16'h4321);
		send_data(0, 0, 0, 16'h8000);
		send_data(0, 0, 1, 16'h7FFF);
		send_data(1, 0, 0, 16'h8000);
		send_data(1, 0, 1, 16'hFFFF);
		send_data(0, 7, 0, 16'h7FFF);
		send_data(0, 7, 1, 16'h0000);
		send_data(1, 7, 0, 16'h0001);
		send_data(1, 7, 1, 16'h8000);
		send(MODE_DATA, 2, 3, 1, 0, 16'h5555);
		send(MODE_DATA, 1, 4, 15, 15, 16'hAAAA);

		idle_pct = 25;
		set_config(16, 16, 1);
		random_phase(30);
		quiesce();
		random_phase(30);
		set_config(3, 5, 4);
		random_phase(60);
		set_config(31, 1, 7);
		random_phase(70);
		set_config(1, 20, 1);
		random_phase(40);
		set_config(0, 4, 2);
		scatter(12);
		set_config(4, 0, 2);
		scatter(12);
		set_config(5, 7, 0);
		scatter(12);
		repeat (3) begin
			set_config($urandom_range(1, 16), $urandom_range(1, 8), $urandom_range(1, 4));
			idle_pct = $urandom_range(0, 40);
			random_phase(50);
		end

		idle_pct = 20;
		set_config(16, 2, 1);
		for (ic = 0; ic < 16; ic++) begin
			send(MODE_WEIGHT, 0, $urandom_range(0, 7), ic, 0, 16'h8000);
			send(MODE_WEIGHT, 0, $urandom_range(0, 7), ic, 1, 16'h7FFF);
		end
		p = $urandom_range(0, 7);
		send_data(0, p, 0, 16'h8000);
		hold_req = 1'b1;
		for (n = 1; n <= 540; n++) begin
			if (n % 60 == 0)
				send_data(0, p, 15, 16'h8000);
			else
				send_data(0, p, $urandom_range(1, 14),
					($urandom_range(0, 9) == 0) ? pick_value() : 16'h8000);
		end
		send_data(0, p, 15, 16'h8000);

		steady   = 1'b1;
		idle_pct = 0;
		set_config(7, 9, 3);
		random_phase(60);
		quiesce();

		if (errors == 0 && pending == 0)
			$display("grouped_matvec_partial_accumulator test passed");
		else
			$display("grouped_matvec_partial_accumulator test failed");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/gmpa_pkg.sv
rtl/core/gmpa_if.sv
rtl/core/gmpa_ram.sv
rtl/core/gmpa_mac.sv
rtl/core/gmpa_seq.sv
rtl/core/grouped_matvec_partial_accumulator.sv
tb/gmpa_sum_checker.sv
tb/tb_grouped_matvec_partial_accumulator.sv
